### hw/rtl/smc_pkg.sv
// shared types and constants for the shutter motor controller
package smc_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_UP   = 2'd1,
    REQ_DOWN = 2'd2,
    REQ_STOP = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_CURRENT_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_TRAVEL_TIMEOUT    = 2'd1;
  localparam logic [1:0] CFG_RELEASE_WINDOW    = 2'd2;
  localparam logic [1:0] CFG_SAMPLE_PERIOD     = 2'd3;

  localparam logic [15:0] THRESHOLD_RST       = 16'd40;
  localparam logic [13:0] TRAVEL_TIMEOUT_RST  = 14'd10000;
  localparam logic [11:0] RELEASE_WINDOW_RST  = 12'd1000;
  localparam logic [11:0] SAMPLE_PERIOD_RST   = 12'd1000;
  localparam logic [11:0] SAMPLE_TIMER_RST    = 12'd1000;
  localparam logic [11:0] IDLE_RELEASE_LOAD   = 12'd2000;

  // current scaling: sample * 619 / 64
  localparam logic [9:0]  CURRENT_SCALE_MUL   = 10'd619;
  localparam int          CURRENT_SCALE_SHIFT = 6;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic [15:0] current_threshold;
    logic [13:0] travel_timeout_ms;
    logic [11:0] release_window_ms;
    logic [11:0] sample_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [11:0] adc_sample;
    logic [1:0]  movement_request;
    logic        release_down;
    logic        release_up;
    logic        press_down;
    logic        press_up;
    logic        ms_tick;
  } item_t;

  typedef struct packed {
    logic       end_of_travel;
    logic [1:0] motion_mode;
    logic       drive_down;
    logic       drive_up;
  } res_t;

endpackage

### hw/rtl/smc_core.sv
// controller state and single-pass step logic
module smc_core import smc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  mode_t       mode_r, mode_nxt;
  mode_t       last_mode_r, last_mode_nxt;
  logic [13:0] travel_timer_r, travel_timer_nxt;
  logic [11:0] release_timer_r, release_timer_nxt;
  logic [11:0] sample_timer_r, sample_timer_nxt;
  logic        arrived_r, arrived_nxt;
  logic [1:0]  drive_r, drive_nxt;   // bit0 up line, bit1 down line

  logic [13:0] tt_tick;
  logic [11:0] rt_tick;
  logic [11:0] st_tick;
  logic [21:0] product;
  logic [15:0] scaled;
  logic        arrived_chk;
  logic        is_up;
  logic        rel_same;
  logic        stop;
  req_t        req;

  always_comb begin
    req = req_t'(item.movement_request);

    // millisecond tick
    tt_tick = travel_timer_r;
    rt_tick = release_timer_r;
    st_tick = sample_timer_r;
    if (item.ms_tick) begin
      if (travel_timer_r != '0)  tt_tick = travel_timer_r - 14'd1;
      if (release_timer_r != '0) rt_tick = release_timer_r - 12'd1;
      if (sample_timer_r != '0)  st_tick = sample_timer_r - 12'd1;
    end

    // current check
    product     = 22'(item.adc_sample) * 22'(CURRENT_SCALE_MUL);
    scaled      = product[21:CURRENT_SCALE_SHIFT];
    arrived_chk = arrived_r;
    sample_timer_nxt = st_tick;
    if (st_tick == '0) begin
      sample_timer_nxt = cfg.sample_period_ms;
      if (scaled > cfg.current_threshold) arrived_chk = 1'b1;
    end

    // mode step
    last_mode_nxt     = mode_r;
    mode_nxt          = mode_r;
    travel_timer_nxt  = tt_tick;
    release_timer_nxt = rt_tick;
    arrived_nxt       = arrived_chk;
    drive_nxt         = drive_r;
    is_up             = (mode_r == MODE_UP);
    rel_same          = 1'b0;
    stop              = 1'b0;

    if (mode_r == MODE_UP || mode_r == MODE_DOWN) begin
      if (mode_r != last_mode_r) begin
        release_timer_nxt = cfg.release_window_ms;
        travel_timer_nxt  = cfg.travel_timeout_ms;
        drive_nxt         = is_up ? 2'b01 : 2'b10;
      end
      if (req == REQ_UP) mode_nxt = is_up ? MODE_IDLE : MODE_UP;
      if (req == REQ_DOWN) begin
        mode_nxt = MODE_DOWN;
      end else begin
        rel_same = is_up ? item.release_up : item.release_down;
        stop = (travel_timer_nxt == '0) || item.press_up || item.press_down ||
               arrived_chk || (release_timer_nxt != '0 && rel_same) ||
               (req == REQ_STOP);
        if (stop) begin
          arrived_nxt = 1'b0;
          mode_nxt    = MODE_IDLE;
        end
      end
      if (mode_nxt != mode_r) drive_nxt = 2'b00;
    end else begin
      release_timer_nxt = IDLE_RELEASE_LOAD;
      if (item.press_down || req == REQ_DOWN)   mode_nxt = MODE_DOWN;
      else if (item.press_up || req == REQ_UP)  mode_nxt = MODE_UP;
    end

    res.drive_up      = drive_nxt[0];
    res.drive_down    = drive_nxt[1];
    res.motion_mode   = mode_nxt;
    res.end_of_travel = arrived_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_IDLE;
      last_mode_r     <= MODE_IDLE;
      travel_timer_r  <= '0;
      release_timer_r <= '0;
      sample_timer_r  <= SAMPLE_TIMER_RST;
      arrived_r       <= 1'b0;
      drive_r         <= 2'b00;
    end else if (step_en) begin
      mode_r          <= mode_nxt;
      last_mode_r     <= last_mode_nxt;
      travel_timer_r  <= travel_timer_nxt;
      release_timer_r <= release_timer_nxt;
      sample_timer_r  <= sample_timer_nxt;
      arrived_r       <= arrived_nxt;
      drive_r         <= drive_nxt;
    end
  end

endmodule

### hw/rtl/shutter_motor_controller.sv
// shutter motor controller top level: config registers, input and output stages
// an accepted beat waits in the input register, its result is registered in the output
// register and leaves from there as a result beat
// one beat per cycle unless stalled, the core state updates in a single pass per beat
// the input register and output register let a new beat in while a result waits
// reset (rst_n low, synchronous) clears modes, travel and release timers, flags and
// both stage valids, presets the sample timer and returns config registers to defaults
module shutter_motor_controller import smc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] ms_tick, [1] press_up, [2] press_down, [3] release_up, [4] release_down,
  // [6:5] movement_request, [18:7] adc_sample, [23:19] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] drive_up, [1] drive_down, [3:2] motion_mode, [4] end_of_travel, [7:5] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata
);

  cfg_t  cfg_r;
  item_t item_r;
  logic  in_vld_r;
  logic  out_vld_r;
  res_t  res_r;
  res_t  res;
  logic  advance;

  // configuration registers: the user writes only while the block is quiet; not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_threshold <= THRESHOLD_RST;
      cfg_r.travel_timeout_ms <= TRAVEL_TIMEOUT_RST;
      cfg_r.release_window_ms <= RELEASE_WINDOW_RST;
      cfg_r.sample_period_ms  <= SAMPLE_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURRENT_THRESHOLD: cfg_r.current_threshold <= cfg_wdata;
        CFG_TRAVEL_TIMEOUT:    cfg_r.travel_timeout_ms <= cfg_wdata[13:0];
        CFG_RELEASE_WINDOW:    cfg_r.release_window_ms <= cfg_wdata[11:0];
        CFG_SAMPLE_PERIOD:     cfg_r.sample_period_ms  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // the held beat moves into the core whenever the output register can take it
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[18:0]);
    end
  end

  // state update and step logic
  smc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, res_r};

endmodule

### tb/shutter_motor_controller_test.sv
// self-checking stream testbench for the shutter motor controller
module shutter_motor_controller_test;
  import smc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // clock, reset and every block input start at known levels
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [0] ms_tick, [1] press_up, [2] press_down, [3] release_up, [4] release_down,
  // [6:5] movement_request, [18:7] adc_sample, [23:19] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] drive_up, [1] drive_down, [3:2] motion_mode, [4] end_of_travel, [7:5] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = CFG_CURRENT_THRESHOLD;
  logic [15:0]           cfg_wdata = '0;

  shutter_motor_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // controller prediction: own copy of the registers and the running state
  // ---------------------------------------------------------------------------
  logic [15:0] thr_cfg     = THRESHOLD_RST;
  logic [13:0] travel_cfg  = TRAVEL_TIMEOUT_RST;
  logic [11:0] release_cfg = RELEASE_WINDOW_RST;
  logic [11:0] sample_cfg  = SAMPLE_PERIOD_RST;

  mode_t       sh_mode      = MODE_IDLE;
  mode_t       sh_last_mode = MODE_IDLE;
  logic [13:0] travel_left  = '0;
  logic [11:0] release_left = '0;
  logic [11:0] sample_left  = SAMPLE_TIMER_RST;
  logic        arrived      = 1'b0;
  logic [1:0]  lines        = 2'b00;   // bit 0 up line, bit 1 down line

  // motor outputs still owed by the block, oldest first
  res_t expected_motor_outputs[$];
  int   fail_count = 0;
  int   burst_left = 0;

  // one controller step: tick, then current check, then mode machine
  function automatic res_t shutter_step(item_t it);
    int unsigned scaled;
    logic        entering;
    logic        is_up;
    logic        stop;
    mode_t       nxt;
    res_t        r;
    if (it.ms_tick) begin
      if (travel_left != 0) travel_left--;
      if (release_left != 0) release_left--;
      if (sample_left != 0) sample_left--;
    end
    // current check, full width so the scaled value never wraps
    if (sample_left == 0) begin
      sample_left = sample_cfg;
      scaled = (int'(it.adc_sample) * int'(CURRENT_SCALE_MUL)) >> CURRENT_SCALE_SHIFT;
      if (scaled > int'(thr_cfg)) arrived = 1'b1;
    end
    entering = (sh_mode != sh_last_mode);
    sh_last_mode = sh_mode;
    nxt = sh_mode;
    if (sh_mode == MODE_UP || sh_mode == MODE_DOWN) begin
      is_up = (sh_mode == MODE_UP);
      // entry actions land one step after the mode changed
      if (entering) begin
        release_left = release_cfg;
        travel_left  = travel_cfg;
        lines        = is_up ? 2'b01 : 2'b10;
      end
      if (it.movement_request == REQ_UP) begin
        if (is_up) nxt = MODE_IDLE;
        else nxt = MODE_UP;
      end
      if (it.movement_request == REQ_DOWN) begin
        nxt = MODE_DOWN;
      end else begin
        stop = (travel_left == 0) || it.press_up || it.press_down || arrived ||
               (release_left != 0 && (is_up ? it.release_up : it.release_down)) ||
               (it.movement_request == REQ_STOP);
        if (stop) begin
          arrived = 1'b0;
          nxt = MODE_IDLE;
        end
      end
      if (nxt != sh_mode) lines = 2'b00;
    end else begin
      release_left = IDLE_RELEASE_LOAD;
      if (it.press_down || it.movement_request == REQ_DOWN) nxt = MODE_DOWN;
      else if (it.press_up || it.movement_request == REQ_UP) nxt = MODE_UP;
    end
    sh_mode = nxt;
    r.drive_up      = lines[0];
    r.drive_down    = lines[1];
    r.motion_mode   = sh_mode;
    r.end_of_travel = arrived;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  logic [7:0]  ready_pattern = 8'hFF;
  int          pattern_left  = 0;
  int unsigned pattern_pos   = 0;

  // ready follows a repeating 8-bit pattern that is re-drawn when a random countdown ends;
  // a third of the patterns are all-ready so long stall-free stretches occur
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      pattern_left  = $urandom_range(16, 64);
      ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
    end
    pattern_left--;
    pattern_pos = (pattern_pos + 1) % 8;
    out_tready <= ready_pattern[pattern_pos];
  end

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  res_t got_res;
  res_t want_res;

  // every accepted result beat is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = res_t'(out_tdata[$bits(res_t)-1:0]);
      if (expected_motor_outputs.size() == 0) begin
        $error("result beat with no prediction pending: %0h", out_tdata);
        fail_count++;
      end else begin
        want_res = expected_motor_outputs.pop_front();
        compare_field("drive_up", 32'(want_res.drive_up), 32'(got_res.drive_up));
        compare_field("drive_down", 32'(want_res.drive_down), 32'(got_res.drive_down));
        compare_field("motion_mode", 32'(want_res.motion_mode),
                      32'(got_res.motion_mode));
        compare_field("end_of_travel", 32'(want_res.end_of_travel),
                      32'(got_res.end_of_travel));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // sends one event beat; bursts of random length separated by idle gaps.
  // the prediction is queued as the beat is offered, ahead of any result
  task automatic send_item(input item_t it);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    expected_motor_outputs.push_back(shutter_step(it));
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(it);
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering beats and wait until every prediction has been matched,
  // then idle on to cover the two-stage pipe
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_motor_outputs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // writes all four registers back to back, only with the block idle
  task automatic set_config(int unsigned thr, int unsigned trv, int unsigned rel,
                            int unsigned smp);
    logic [15:0] vals [4];
    logic [1:0]  regs [4];
    drain();
    vals = '{16'(thr), 16'(trv & 32'h3FFF), 16'(rel & 32'hFFF), 16'(smp & 32'hFFF)};
    regs = '{CFG_CURRENT_THRESHOLD, CFG_TRAVEL_TIMEOUT, CFG_RELEASE_WINDOW,
             CFG_SAMPLE_PERIOD};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    thr_cfg     = vals[0];
    travel_cfg  = vals[1][13:0];
    release_cfg = vals[2][11:0];
    sample_cfg  = vals[3][11:0];
  endtask

  function automatic item_t ev(int unsigned tick, int unsigned pu, int unsigned pd,
                               int unsigned ru, int unsigned rd,
                               req_t req, logic [11:0] adc);
    item_t it;
    it.ms_tick          = tick[0];
    it.press_up         = pu[0];
    it.press_down       = pd[0];
    it.release_up       = ru[0];
    it.release_down     = rd[0];
    it.movement_request = req;
    it.adc_sample       = adc;
    return it;
  endfunction

  // random event shaped by the predicted mode: idle mostly waits for a start,
  // a movement mostly runs on ticks and now and then sees a stop or reversal;
  // one beat in ten is pure noise
  function automatic item_t random_event(int unsigned adc_hi);
    item_t       it;
    int          pick;
    logic [31:0] raw;
    it = '0;
    if ($urandom_range(0, 9) == 0) begin
      raw = $urandom;
      it  = raw[$bits(item_t)-1:0];
    end else begin
      it.ms_tick    = ($urandom_range(0, 99) < 60);
      it.adc_sample = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                  : 12'($urandom_range(0, adc_hi));
      pick = $urandom_range(0, 99);
      if (sh_mode == MODE_IDLE) begin
        if (pick < 10) it.press_up = 1'b1;
        else if (pick < 20) it.press_down = 1'b1;
        else if (pick < 30) it.movement_request = REQ_UP;
        else if (pick < 40) it.movement_request = REQ_DOWN;
        else if (pick < 45) it.release_up = 1'b1;
        else if (pick < 50) it.release_down = 1'b1;
      end else begin
        if (pick < 70) begin
          // keep moving
        end else if (pick < 74) it.press_up = 1'b1;
        else if (pick < 78) it.press_down = 1'b1;
        else if (pick < 84) it.release_up = 1'b1;
        else if (pick < 90) it.release_down = 1'b1;
        else if (pick < 93) it.movement_request = REQ_UP;
        else if (pick < 96) it.movement_request = REQ_DOWN;
        else if (pick < 98) it.movement_request = REQ_STOP;
        else begin
          it.movement_request = REQ_UP;
          it.press_up = 1'b1;
        end
      end
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // moves, stops and reversals with the reset register values
  task automatic test_basic_moves();
    send_item(ev(0, 0, 0, 0, 0, REQ_NONE, 12'd0));     // idle stays idle
    send_item(ev(1, 1, 0, 0, 0, REQ_NONE, 12'd4095));  // up press starts up
    send_item(ev(1, 0, 0, 0, 0, REQ_NONE, 12'hAAA));   // entry step raises up line
    send_item(ev(1, 0, 0, 1, 0, REQ_NONE, 12'h555));   // quick release of up stops
    send_item(ev(0, 0, 0, 0, 0, REQ_DOWN, 12'd0));     // remote down
    send_item(ev(0, 0, 0, 0, 0, REQ_DOWN, 12'd0));     // down request holds down
    send_item(ev(1, 0, 0, 0, 0, REQ_UP, 12'd0));       // reversal, lines low
    send_item(ev(0, 0, 0, 0, 1, REQ_NONE, 12'd0));     // other button release ignored
    send_item(ev(0, 0, 0, 0, 0, REQ_UP, 12'd0));       // up request while up goes idle
    send_item(ev(0, 1, 1, 0, 0, REQ_NONE, 12'd0));     // both presses: down wins
    send_item(ev(0, 0, 0, 0, 0, REQ_STOP, 12'd0));     // remote stop
    send_item(ev(0, 0, 0, 0, 0, REQ_UP, 12'd0));       // remote up from idle
    send_item(ev(0, 0, 0, 0, 0, REQ_DOWN, 12'd0));     // reversal up to down
  endtask

  // latch while idle, zero timeout, zero sample period, window edges
  task automatic test_special_cases();
    set_config(0, 0, 0, 0);
    // run the reset sample countdown down so the current check comes into play
    while (sample_left > 1) send_item(ev(1, 0, 0, 0, 0, REQ_NONE, 12'd0));
    send_item(ev(1, 0, 0, 0, 0, REQ_NONE, 12'd1));     // check fires in idle, latches
    send_item(ev(0, 1, 0, 0, 0, REQ_NONE, 12'd0));     // start up with flag held
    send_item(ev(0, 0, 0, 0, 0, REQ_NONE, 12'd0));     // flag stops first step
    send_item(ev(0, 0, 0, 0, 0, REQ_DOWN, 12'd0));     // start down
    send_item(ev(0, 0, 0, 0, 0, REQ_NONE, 12'd0));     // zero timeout stops at once
    set_config(65535, 16383, 4095, 1);
    send_item(ev(1, 0, 0, 0, 0, REQ_UP, 12'd4095));    // largest current, no latch
    send_item(ev(1, 0, 0, 0, 1, REQ_NONE, 12'd4095));
    send_item(ev(1, 0, 0, 1, 0, REQ_NONE, 12'd0));     // release inside wide window
    send_item(ev(0, 0, 0, 0, 0, REQ_DOWN, 12'd0));
    send_item(ev(0, 0, 0, 0, 0, REQ_NONE, 12'd0));
    send_item(ev(0, 1, 0, 0, 0, REQ_UP, 12'd0));       // stop beats the move to up
    send_item(ev(0, 0, 1, 0, 0, REQ_NONE, 12'd0));
    send_item(ev(0, 0, 0, 0, 0, REQ_UP, 12'd0));       // down to up without a stop
  endtask

  // one register setting, then a stream of mode-aware random events
  task automatic test_random_phase(int unsigned thr, int unsigned trv, int unsigned rel,
                                   int unsigned smp, int n_events, int unsigned adc_hi);
    set_config(thr, trv, rel, smp);
    repeat (n_events) send_item(random_event(adc_hi));
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_moves();
    test_special_cases();
    // short timers and windows so movements end inside the phase
    test_random_phase(60, 12, 5, 2, 70, 10);
    test_random_phase(30, 25, 10, 0, 70, 6);
    // everything at zero: latch on any current, stop on first step
    test_random_phase(0, 0, 0, 0, 50, 15);
    repeat (2) begin
      test_random_phase($urandom_range(10, 90), $urandom_range(1, 40), $urandom_range(0, 20),
                        $urandom_range(0, 5), 60, 12);
    end
    // threshold above the largest scaled current, longest timers
    test_random_phase(40000, 16383, 4095, 1, 60, 4095);
    // largest period last: the countdown does not come back within the run
    test_random_phase(65535, 20, 8, 4095, 60, 4095);
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
